// ===== rtl/core/sidta_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package sidta_pkg;

   // Width of the input integer and of one output character.
   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned CHAR_WIDTH  = 8;

   // A 32-bit magnitude has at most ten decimal digits.
   localparam int unsigned DIGIT_COUNT = 10;
   localparam int unsigned COUNT_WIDTH = 4;

   // Depth of the queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Character codes.
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x.
   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int unsigned            RECIP_SHIFT = 35;

   typedef logic [3:0] digit_type;

   // One classified item: sign flag and unsigned magnitude.
   typedef struct packed {
      logic                   neg;
      logic [VALUE_WIDTH-1:0] mag;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/signed_int_to_decimal_ascii_unit.sv =====
// Signed 32-bit integer to decimal ASCII text, one character per output item.
// The back takes an item only in its idle state, runs the divide-by-ten loop once
// per digit, then emits the sign (if any) and the digits; it takes no new item
// before it has loaded the last character of the previous one into its output.
// A two-entry queue lets the front accept items meanwhile.
// Reset is synchronous and active high; it empties the queue and the output.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [sidta_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [sidta_pkg::CHAR_WIDTH-1:0]         rsp_ascii_char,
   output logic                                     rsp_last_char
);

   logic                 fr_valid, fr_ready;
   sidta_pkg::entry_type fr_data;
   logic                 bk_valid, bk_ready;
   sidta_pkg::entry_type bk_data;

   // Front: accept and classify.
   sidta_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .ent_valid (fr_valid),
      .ent_ready (fr_ready),
      .ent_data  (fr_data)
   );

   // Queue between the two halves.
   sidta_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_data  (fr_data),
      .rd_valid (bk_valid),
      .rd_ready (bk_ready),
      .rd_data  (bk_data)
   );

   // Back: convert and emit characters.
   sidta_back u_back (
      .clock          (clock),
      .reset          (reset),
      .ent_valid      (bk_valid),
      .ent_ready      (bk_ready),
      .ent_data       (bk_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

`default_nettype wire

// ===== rtl/core/sidta_front.sv =====
// Front stage: accepts an input item, splits it into sign and magnitude.
// Depends on sidta_pkg.
`default_nettype none

module sidta_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [sidta_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                     ent_valid,
   input  wire logic                                ent_ready,
   output sidta_pkg::entry_type                     ent_data
);

   logic                 stage_valid_ff;
   logic                 stage_valid_in;
   sidta_pkg::entry_type stage_ff;
   sidta_pkg::entry_type stage_in;
   logic                 take;

   // The stage takes a new item when it is empty or is being drained.
   assign req_ready = !stage_valid_ff || ent_ready;
   assign take      = req_valid && req_ready;

   // Classify: the magnitude is the two's complement negation taken as unsigned,
   // which is also right for the most negative value.
   always_comb begin
      stage_in.neg = req_value[sidta_pkg::VALUE_WIDTH-1];
      if (req_value[sidta_pkg::VALUE_WIDTH-1]) begin
         stage_in.mag = (~req_value) + 32'd1;
      end else begin
         stage_in.mag = req_value;
      end
   end

   always_comb begin
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (ent_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= stage_in;
      end
   end

   assign ent_valid = stage_valid_ff;
   assign ent_data  = stage_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sidta_queue.sv =====
// Short FIFO of classified items between the front and the back.
// Depends on sidta_pkg.
`default_nettype none

module sidta_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_valid,
   output logic                      wr_ready,
   input  wire sidta_pkg::entry_type wr_data,
   output logic                      rd_valid,
   input  wire logic                 rd_ready,
   output sidta_pkg::entry_type      rd_data
);

   localparam int unsigned PTR_WIDTH = $clog2(sidta_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_WIDTH = $clog2(sidta_pkg::QUEUE_DEPTH + 1);

   sidta_pkg::entry_type mem_ff [sidta_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 push, pop;

   assign wr_ready = (count_ff != CNT_WIDTH'(sidta_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rd_ptr_ff];

   // Pointer and occupancy updates; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(sidta_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(sidta_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sidta_back.sv =====
// Back end: divides the magnitude by ten once per cycle onto a digit stack,
// then emits the sign and the digits, most significant first. Depends on sidta_pkg.
`default_nettype none

module sidta_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              ent_valid,
   output logic                                   ent_ready,
   input  wire sidta_pkg::entry_type              ent_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [sidta_pkg::CHAR_WIDTH-1:0]       rsp_ascii_char,
   output logic                                   rsp_last_char
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGS
   } state_type;

   localparam int unsigned VW = sidta_pkg::VALUE_WIDTH;
   localparam int unsigned QW = VW - 3;   // quotient of a 32-bit value by ten
   localparam int unsigned CW = sidta_pkg::COUNT_WIDTH;

   state_type                  state_ff, state_in;
   logic                       neg_ff, neg_in;
   logic [VW-1:0]              mag_ff, mag_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   sidta_pkg::digit_type       stack_ff [sidta_pkg::DIGIT_COUNT];
   sidta_pkg::digit_type       stack_in [sidta_pkg::DIGIT_COUNT];
   logic                       out_valid_ff, out_valid_in;
   logic [sidta_pkg::CHAR_WIDTH-1:0] out_char_ff, out_char_in;
   logic                       out_last_ff, out_last_in;

   logic [2*VW-1:0]            product;
   logic [QW-1:0]              quot;
   logic [VW-1:0]              rem_full;
   sidta_pkg::digit_type       rem;
   logic                       load_out;

   // Divide by ten through the reciprocal; the remainder is below ten.
   always_comb begin
      product  = {{VW{1'b0}}, mag_ff} * {{VW{1'b0}}, sidta_pkg::RECIP_TEN};
      quot     = product[2*VW-1:sidta_pkg::RECIP_SHIFT];
      rem_full = mag_ff - (({3'b000, quot} << 3) + ({3'b000, quot} << 1));
      rem      = rem_full[3:0];
   end

   assign ent_ready = (state_ff == ST_IDLE);
   assign load_out  = !out_valid_ff || rsp_ready;

   // Sequencer: fetch, convert, then emit one character per free output slot.
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      stack_in     = stack_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (ent_valid) begin
               neg_in   = ent_data.neg;
               mag_in   = ent_data.mag;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // Push the low digit; a zero magnitude still yields one digit.
            stack_in[0] = rem;
            for (int i = 1; i < sidta_pkg::DIGIT_COUNT; i++) begin
               stack_in[i] = stack_ff[i-1];
            end
            mag_in = {3'b000, quot};
            cnt_in = cnt_ff + 1'b1;
            if (quot == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGS;
            end
         end
         ST_SIGN: begin
            if (load_out) begin
               out_valid_in = 1'b1;
               out_char_in  = sidta_pkg::ASCII_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_DIGS;
            end
         end
         ST_DIGS: begin
            if (load_out) begin
               out_valid_in = 1'b1;
               out_char_in  = sidta_pkg::ASCII_ZERO + {4'b0000, stack_ff[0]};
               out_last_in  = (cnt_ff == CW'(1));
               for (int i = 0; i < sidta_pkg::DIGIT_COUNT - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      stack_ff    <= stack_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ascii_char = out_char_ff;
   assign rsp_last_char  = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sidta_checker.sv =====
// Port-level assertions for the decimal ASCII unit, bound to the top level.
// Depends on sidta_pkg and signed_int_to_decimal_ascii_unit.
`default_nettype none

module sidta_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic [sidta_pkg::VALUE_WIDTH-1:0]   req_value,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [sidta_pkg::CHAR_WIDTH-1:0]    rsp_ascii_char,
   input wire logic                                rsp_last_char
);

   // A waiting input item stays presented with the same value.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_value))
      else $error("waiting input item changed");

   // A stalled item holds its character and end mark.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_ascii_char) && $stable(rsp_last_char))
      else $error("stalled output item changed");

   // Every character is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == sidta_pkg::ASCII_MINUS) ||
                    ((rsp_ascii_char >= sidta_pkg::ASCII_ZERO) &&
                     (rsp_ascii_char <= sidta_pkg::ASCII_ZERO + 8'd9)))
      else $error("output character out of range");

   // A minus sign never ends a run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ascii_char == sidta_pkg::ASCII_MINUS) |-> !rsp_last_char)
      else $error("minus sign marked as last");

   // Reset leaves no item pending on the output.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii_unit sidta_checker u_sidta_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_value      (req_value),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_ascii_char (rsp_ascii_char),
   .rsp_last_char  (rsp_last_char)
);

`default_nettype wire
